[rtl/wss_pkg.sv]
// Shared types and constants for the windowed sample statistics block.
package wss_pkg;

    localparam int unsigned StoreDepth = 1024;
    localparam int unsigned TimeW  = 32;
    localparam int unsigned ValW   = 12;
    localparam int unsigned WinW   = 24;
    localparam int unsigned CntW   = $clog2(StoreDepth + 1);
    localparam int unsigned InW    = TimeW + ValW + TimeW + TimeW;      // 108
    localparam int unsigned InBytW = 112;
    localparam int unsigned OutW   = 1 + ValW * 3 + CntW * 2 + 1;       // 60
    localparam int unsigned OutBytW = 64;
    localparam logic [WinW-1:0] WinReset = 24'd86400;
    localparam logic [ValW-1:0] ValMax = 12'sh7FF;
    localparam logic [ValW-1:0] ValMin = 12'sh800;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HRD,
        ST_HCHK,
        ST_TRD,
        ST_TCHK,
        ST_WRITE,
        ST_QRD,
        ST_QACC,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

[rtl/wss_ram.sv]
// Generic single-port RAM with registered read.
module wss_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

[rtl/windowed_sample_statistics.sv]
// Top level: timestamped sample ring store with windowed min/max/mean queries.
//
// Channel  | Dir | Payload
// s_axis   | in  | tuser: op; tdata: sample_time, sample_value, range_from, range_to
// m_axis   | out | tdata: found, min, max, mean, match_count, stored_count, dropped
// apb      | in  | reg 0 window_seconds at byte 0
//
// Add: drops entries at either end, then writes the new one. Query: scans every
// stored entry, then divider load, 23 quotient bits, one per cycle, and the
// result beat; when nothing matches, the divider is skipped.
// Reset is synchronous; the store needs no clearing. Input is not ready while
// an item is in work or a result beat waits on m_axis_tready.
module windowed_sample_statistics (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [0] op
    input  logic                         s_axis_tuser,
    // [31:0] sample_time, [43:32] sample_value, [75:44] range_from,
    // [107:76] range_to, zero pad
    input  logic [wss_pkg::InBytW-1:0]   s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [0] found, [12:1] min, [24:13] max, [36:25] mean, [47:37] match_count,
    // [58:48] stored_count, [59] dropped_oldest, zero pad
    output logic [wss_pkg::OutBytW-1:0]  m_axis_tdata,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [1:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import wss_pkg::*;

    localparam int unsigned AW  = $clog2(StoreDepth);
    localparam int unsigned CW  = CntW;
    localparam int unsigned SW  = ValW + CW;
    localparam logic [CW-1:0] Depth = CW'(StoreDepth);

    t_state r_state, n_state;
    logic [WinW-1:0]  r_win;
    logic [AW-1:0]    r_head, n_head;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [CW-1:0]    r_k, n_k;
    logic [TimeW-1:0] r_t, r_from, r_to;
    logic [ValW-1:0]  r_v;
    logic             r_drop, n_drop;
    logic [ValW-1:0]  r_mn, n_mn, r_mx, n_mx;
    logic [SW-1:0]    r_sum, n_sum;
    logic [CW-1:0]    r_mc, n_mc;
    logic [SW-1:0]    r_quo, n_quo;
    logic [CW:0]      r_rem, n_rem;
    logic [$clog2(SW+1)-1:0] r_dc, n_dc;
    logic             r_neg;
    logic [OutW-1:0]  r_out, n_out;

    logic             ram_we;
    logic [AW-1:0]    ram_addr;
    logic [TimeW-1:0] t_rd;
    logic [ValW-1:0]  v_rd;
    logic [CW-1:0]    slot_sum;
    logic [CW-1:0]    off;
    logic signed [TimeW+1:0] cutoff;
    logic [SW-1:0]    abs_sum;
    logic [CW:0]      rem_sh;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {8'd0, r_win} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= WinReset;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            r_win <= pwdata[WinW-1:0];
        end
    end

    always_comb begin
        slot_sum = CW'(r_head) + off;
        if (slot_sum >= Depth) begin
            slot_sum = slot_sum - Depth;
        end
    end
    assign ram_addr = slot_sum[AW-1:0];

    wss_ram #(.WIDTH(TimeW), .DEPTH(StoreDepth)) u_tram (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr), .i_wdata(r_t), .o_rdata(t_rd));
    wss_ram #(.WIDTH(ValW), .DEPTH(StoreDepth)) u_vram (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr), .i_wdata(r_v), .o_rdata(v_rd));

    assign cutoff  = $signed({2'b00, r_t}) - $signed({10'd0, r_win});
    assign abs_sum = r_sum[SW-1] ? SW'(-r_sum) : r_sum;
    assign rem_sh  = {r_rem[CW-1:0], r_quo[SW-1]};
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = {{(OutBytW-OutW){1'b0}}, r_out};

    // address offset and write enable
    always_comb begin
        off    = '0;
        ram_we = 1'b0;
        unique case (r_state)
            ST_HRD, ST_HCHK: off = '0;
            ST_TRD, ST_TCHK: off = r_cnt - CW'(1);
            ST_WRITE: begin
                off    = r_cnt;
                ram_we = 1'b1;
            end
            ST_QRD, ST_QACC: off = r_k;
            default: off = '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_head = r_head;
        n_cnt  = r_cnt;
        n_k    = r_k;
        n_drop = r_drop;
        n_mn   = r_mn;
        n_mx   = r_mx;
        n_sum  = r_sum;
        n_mc   = r_mc;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dc   = r_dc;
        n_out  = r_out;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_drop = 1'b0;
                    n_k    = '0;
                    n_mn   = ValMax;
                    n_mx   = ValMin;
                    n_sum  = '0;
                    n_mc   = '0;
                    n_state = (s_axis_tuser == OP_QUERY) ? ST_QRD : ST_HRD;
                end
            end
            ST_HRD: n_state = (r_cnt == '0) ? ST_TRD : ST_HCHK;
            ST_HCHK: begin
                if ($signed({2'b00, t_rd}) <= cutoff) begin
                    n_head = (r_head == AW'(StoreDepth - 1)) ? '0 : r_head + AW'(1);
                    n_cnt  = r_cnt - CW'(1);
                    n_state = ST_HRD;
                end else begin
                    n_state = ST_TRD;
                end
            end
            ST_TRD: begin
                if (r_cnt == '0) begin
                    n_state = ST_WRITE;
                end else if (r_cnt == Depth) begin
                    n_state = ST_TCHK;
                end else begin
                    n_state = ST_TCHK;
                end
            end
            ST_TCHK: begin
                if (t_rd >= r_t) begin
                    n_cnt   = r_cnt - CW'(1);
                    n_state = ST_TRD;
                end else if (r_cnt >= Depth) begin
                    n_head = (r_head == AW'(StoreDepth - 1)) ? '0 : r_head + AW'(1);
                    n_cnt  = r_cnt - CW'(1);
                    n_drop = 1'b1;
                    n_state = ST_WRITE;
                end else begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                n_cnt = r_cnt + CW'(1);
                n_out = {r_drop, r_cnt + CW'(1), {CW{1'b0}}, {(3*ValW){1'b0}}, 1'b0};
                n_state = ST_OUT;
            end
            ST_QRD: n_state = (r_k == r_cnt) ? ST_DIV : ST_QACC;
            ST_QACC: begin
                if (r_from <= t_rd && t_rd <= r_to) begin
                    if ($signed(v_rd) < $signed(r_mn)) n_mn = v_rd;
                    if ($signed(v_rd) > $signed(r_mx)) n_mx = v_rd;
                    n_sum = r_sum + SW'($signed(v_rd));
                    n_mc  = r_mc + CW'(1);
                end
                n_k = r_k + CW'(1);
                n_state = ST_QRD;
                if (n_state == ST_QRD && r_k + CW'(1) == r_cnt) begin
                    n_quo = '0;
                end
            end
            ST_DIV: begin
                if (r_dc == '0 && r_mc != '0) begin
                    // load
                    n_quo = abs_sum;
                    n_rem = '0;
                    n_dc  = ($clog2(SW+1))'(SW);
                end else if (r_dc != '0) begin
                    if (rem_sh >= {1'b0, r_mc}) begin
                        n_rem = rem_sh - {1'b0, r_mc};
                        n_quo = {r_quo[SW-2:0], 1'b1};
                    end else begin
                        n_rem = rem_sh;
                        n_quo = {r_quo[SW-2:0], 1'b0};
                    end
                    n_dc = r_dc - 1'b1;
                    if (r_dc == 1) n_state = ST_OUT;
                end
                if (r_mc == '0) begin
                    n_out = {1'b0, r_cnt, {CW{1'b0}}, {(3*ValW){1'b0}}, 1'b0};
                    n_state = ST_OUT;
                end
            end
            ST_OUT: if (m_axis_tready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
        if (r_state == ST_DIV && r_dc == 1) begin
            n_out = {1'b0, r_cnt, r_mc, (r_neg ? ValW'(-n_quo) : n_quo[ValW-1:0]),
                     r_mx, r_mn, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_cnt   <= '0;
            r_dc    <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_cnt   <= n_cnt;
            r_dc    <= n_dc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && s_axis_tvalid) begin
            r_t    <= s_axis_tdata[31:0];
            r_v    <= s_axis_tdata[43:32];
            r_from <= s_axis_tdata[75:44];
            r_to   <= s_axis_tdata[107:76];
        end
        if (r_state == ST_DIV && r_dc == '0) begin
            r_neg <= r_sum[SW-1];
        end
        r_k   <= n_k;
        r_drop <= n_drop;
        r_mn  <= n_mn;
        r_mx  <= n_mx;
        r_sum <= n_sum;
        r_mc  <= n_mc;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_out <= n_out;
    end
endmodule
